[src/qjtg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qjtg_pkg
// shared types, constants and coefficient function of the trajectory core
// ----------------------------------------------------------------------------
package qjtg_pkg;

    localparam int NAXES   = 3;
    localparam int AX_W    = $clog2(NAXES);
    localparam int CMD_W   = 32;
    localparam int REG_W   = 16;
    localparam int FRAC_T  = 20;
    localparam int ACC_W   = 32;
    localparam int MUL_W   = CMD_W + 1;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int SUM_W   = 48;
    localparam int CNT_W   = $clog2(FRAC_T + 1);
    localparam int HK_W    = 3;

    localparam logic [0:0] CFG_START_VELOCITY = 1'd0;
    localparam logic [0:0] CFG_START_ACCEL    = 1'd1;

    localparam logic [REG_W-1:0] VEL_RESET = 16'd3277;
    localparam logic [REG_W-1:0] ACC_RESET = 16'd18842;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_START = 2'd0;
    localparam kind_t KIND_TICK  = 2'd1;
    localparam kind_t KIND_HOLD  = 2'd2;

    typedef struct packed {
        logic                    opcode;
        logic                    enabled;
        logic signed [CMD_W-1:0] target_a;
        logic signed [CMD_W-1:0] target_b;
        logic signed [CMD_W-1:0] target_c;
        logic [15:0]             move_ticks;
        logic signed [CMD_W-1:0] measured_a;
        logic signed [CMD_W-1:0] measured_b;
        logic signed [CMD_W-1:0] measured_c;
    } in_item_t;

    typedef struct packed {
        logic signed [CMD_W-1:0] command_a;
        logic signed [CMD_W-1:0] command_b;
        logic signed [CMD_W-1:0] command_c;
        logic                    busy_res;
        logic                    done_res;
    } out_item_t;

    typedef struct packed {
        kind_t    kind;
        in_item_t item;
    } q_entry_t;

    typedef struct packed {
        logic idle;
        logic running;
        logic finished;
        logic done_state;
    } back_stat_t;

    // quintic coefficient k scaled from q13 to q20
    function automatic logic signed [ACC_W-1:0] coef_q20(
        input logic [HK_W-1:0]         k,
        input logic signed [REG_W-1:0] v,
        input logic signed [REG_W-1:0] a
    );
        logic signed [ACC_W-1:0] vv;
        logic signed [ACC_W-1:0] aa;
        logic signed [ACC_W-1:0] c;
        vv = ACC_W'(v);
        aa = ACC_W'(a);
        case (k)
            3'd0:    c = 32'sd2 * vv;
            3'd1:    c = aa;
            3'd2:    c = 32'sd81920 - 32'sd12 * vv - 32'sd3 * aa;
            3'd3:    c = -32'sd122880 + 32'sd16 * vv + 32'sd3 * aa;
            default: c = 32'sd49152 - 32'sd6 * vv - aa;
        endcase
        return c <<< 7;
    endfunction

endpackage

[src/qjtg_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qjtg_front
// input beat queue; tags each beat as start, tick or hold
// ----------------------------------------------------------------------------
module qjtg_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  qjtg_pkg::in_item_t in_data,
    output logic              q_valid,
    input  logic              q_ready,
    output qjtg_pkg::q_entry_t q_data
);
    import qjtg_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    q_entry_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    q_entry_t         entry;
    logic             push;
    logic             pop;

    always_comb
    begin
        entry.item = in_data;
        if (!in_data.opcode)
            entry.kind = KIND_START;
        else if (in_data.enabled)
            entry.kind = KIND_TICK;
        else
            entry.kind = KIND_HOLD;
    end

    assign in_ready = (count_reg != (PTR_W+1)'(DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_data   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

[src/qjtg_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qjtg_back
// move state, tick divider, horner sequencer and per-axis blend
// ----------------------------------------------------------------------------
module qjtg_back #(
    parameter int TICK_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    output logic                              q_ready,
    input  qjtg_pkg::q_entry_t                q_data,
    input  logic signed [qjtg_pkg::REG_W-1:0] start_velocity,
    input  logic signed [qjtg_pkg::REG_W-1:0] start_accel,
    output logic                              out_valid,
    input  logic                              out_ready,
    output qjtg_pkg::out_item_t               out_data,
    output qjtg_pkg::back_stat_t              stat
);
    import qjtg_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_HMUL = 3'd2;
    localparam logic [2:0] S_HADD = 3'd3;
    localparam logic [2:0] S_AMUL = 3'd4;
    localparam logic [2:0] S_AADD = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    localparam logic signed [SUM_W-1:0] SAT_MAX = 48'sd2147483647;
    localparam logic signed [SUM_W-1:0] SAT_MIN = -48'sd2147483648;

    logic [2:0]              state_reg;
    logic [TICK_BITS-1:0]    elapsed_reg;
    logic [TICK_BITS-1:0]    total_reg;
    logic signed [CMD_W-1:0] start_reg  [NAXES];
    logic signed [CMD_W-1:0] target_reg [NAXES];
    logic signed [CMD_W-1:0] cmd_reg    [NAXES];
    logic                    running_reg;
    logic                    finished_reg;
    logic [TICK_BITS:0]      rem_reg;
    logic [FRAC_T-1:0]       t_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [HK_W-1:0]         hk_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [CMD_W-1:0] s_reg;
    logic [AX_W-1:0]         ax_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                    out_valid_reg;
    out_item_t               out_data_reg;

    logic signed [CMD_W-1:0]  in_tgt [NAXES];
    logic signed [CMD_W-1:0]  in_mes [NAXES];
    logic                     take;
    logic [TICK_BITS:0]       e1;
    logic [TICK_BITS:0]       sh;
    logic                     ge;
    logic signed [MUL_W-1:0]  diff;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [PROD_W-1:0] shifted;
    logic signed [SUM_W-1:0]  sum;
    logic signed [CMD_W-1:0]  blend;

    assign in_tgt[0] = q_data.item.target_a;
    assign in_tgt[1] = q_data.item.target_b;
    assign in_tgt[2] = q_data.item.target_c;
    assign in_mes[0] = q_data.item.measured_a;
    assign in_mes[1] = q_data.item.measured_b;
    assign in_mes[2] = q_data.item.measured_c;

    assign q_ready = (state_reg == S_IDLE);
    assign take    = q_valid && q_ready;
    assign e1      = {1'b0, elapsed_reg} + 1'b1;
    assign sh      = {rem_reg[TICK_BITS-1:0], 1'b0};
    assign ge      = (sh >= {1'b0, total_reg});

    assign diff    = MUL_W'(target_reg[ax_reg]) - MUL_W'(start_reg[ax_reg]);
    assign mul_a   = (state_reg == S_AMUL) ? diff : MUL_W'(acc_reg);
    assign mul_b   = (state_reg == S_AMUL) ? MUL_W'(s_reg)
                                           : $signed({(MUL_W-FRAC_T)'(0), t_reg});
    assign mul_p   = mul_a * mul_b;
    assign shifted = prod_reg >>> FRAC_T;
    assign sum     = SUM_W'(start_reg[ax_reg]) + $signed(shifted[SUM_W-1:0]);

    always_comb
    begin
        if (sum > SAT_MAX)
            blend = SAT_MAX[CMD_W-1:0];
        else if (sum < SAT_MIN)
            blend = SAT_MIN[CMD_W-1:0];
        else
            blend = sum[CMD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_DIV:
            begin
                rem_reg <= ge ? (sh - {1'b0, total_reg}) : sh;
                t_reg   <= {t_reg[FRAC_T-2:0], ge};
            end
            S_HMUL, S_AMUL:
                prod_reg <= mul_p;
            S_HADD:
            begin
                if (hk_reg == '0)
                    s_reg <= $signed(shifted[CMD_W-1:0]);
                else
                    acc_reg <= coef_q20(hk_reg - 1'b1, start_velocity, start_accel)
                               + $signed(shifted[ACC_W-1:0]);
            end
            default:
            begin
                if (take)
                begin
                    rem_reg <= {1'b0, elapsed_reg};
                    t_reg   <= '0;
                    acc_reg <= coef_q20(3'd4, start_velocity, start_accel);
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            elapsed_reg   <= '0;
            total_reg     <= '0;
            running_reg   <= 1'b0;
            finished_reg  <= 1'b1;
            cnt_reg       <= '0;
            hk_reg        <= '0;
            ax_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            for (int i = 0; i < NAXES; i++)
            begin
                start_reg[i]  <= '0;
                target_reg[i] <= '0;
                cmd_reg[i]    <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != S_DONE)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (take)
                    begin
                        state_reg <= S_DONE;
                        if (q_data.kind == KIND_START)
                        begin
                            for (int i = 0; i < NAXES; i++)
                            begin
                                target_reg[i] <= in_tgt[i];
                                start_reg[i]  <= in_mes[i];
                            end
                            total_reg    <= TICK_BITS'(q_data.item.move_ticks);
                            elapsed_reg  <= '0;
                            running_reg  <= 1'b1;
                            finished_reg <= 1'b0;
                        end
                        else if (q_data.kind == KIND_TICK && running_reg)
                        begin
                            if (e1 >= {1'b0, total_reg})
                            begin
                                for (int i = 0; i < NAXES; i++)
                                    cmd_reg[i] <= target_reg[i];
                                elapsed_reg  <= total_reg;
                                running_reg  <= 1'b0;
                                finished_reg <= 1'b1;
                            end
                            else
                            begin
                                elapsed_reg <= e1[TICK_BITS-1:0];
                                cnt_reg     <= CNT_W'(FRAC_T);
                                state_reg   <= S_DIV;
                            end
                        end
                    end
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                    begin
                        hk_reg    <= HK_W'(4);
                        state_reg <= S_HMUL;
                    end
                end
                S_HMUL:
                    state_reg <= S_HADD;
                S_HADD:
                begin
                    if (hk_reg == '0)
                    begin
                        ax_reg    <= '0;
                        state_reg <= S_AMUL;
                    end
                    else
                    begin
                        hk_reg    <= hk_reg - 1'b1;
                        state_reg <= S_HMUL;
                    end
                end
                S_AMUL:
                    state_reg <= S_AADD;
                S_AADD:
                begin
                    cmd_reg[ax_reg] <= blend;
                    if (ax_reg == AX_W'(NAXES - 1))
                        state_reg <= S_DONE;
                    else
                    begin
                        ax_reg    <= ax_reg + 1'b1;
                        state_reg <= S_AMUL;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg          <= 1'b1;
                        out_data_reg.command_a <= cmd_reg[0];
                        out_data_reg.command_b <= cmd_reg[1];
                        out_data_reg.command_c <= cmd_reg[2];
                        out_data_reg.busy_res  <= running_reg;
                        out_data_reg.done_res  <= finished_reg;
                        state_reg              <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;
    assign stat.idle       = (state_reg == S_IDLE);
    assign stat.running    = running_reg;
    assign stat.finished   = finished_reg;
    assign stat.done_state = (state_reg == S_DONE);

endmodule

[src/quintic_joint_trajectory_generator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quintic_joint_trajectory_generator_core
// three-axis quintic joint trajectory generator, q16.16 positions
// ----------------------------------------------------------------------------
// input beats (in_valid/in_ready) carry either a start of a move (opcode 0)
// or one control tick (opcode 1); every input beat yields exactly one output
// beat (out_valid/out_ready) with the current setpoints and busy/done flags.
// a two-entry queue takes input beats while the sequencer is working.
// start, hold and final ticks pass from the idle state straight to the done state.
// an interpolating tick runs the 20-step tick divider, five horner steps
// on the shared multiplier (multiply, then add) and three axis blends
// (multiply, then add); one item is worked on at a time.
// the user must write start_velocity and start_accel (cfg_we/cfg_index/
// cfg_data) only while the core is idle; the core has no check for this.
// reset clears the queue, idles the sequencer, zeroes all angles, clears
// running and sets done; registers return to 0.8 and 4.6 in q4.12.
// a stalled receiver holds the output beat; the sequencer waits with its
// result and the queue absorbs up to two more input beats.
// ----------------------------------------------------------------------------
module quintic_joint_trajectory_generator_core #(
    parameter int TICK_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  qjtg_pkg::in_item_t          in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output qjtg_pkg::out_item_t         out_data,
    input  logic                        cfg_we,
    input  logic [0:0]                  cfg_index,
    input  logic [qjtg_pkg::REG_W-1:0]  cfg_data
);
    import qjtg_pkg::*;

    logic [REG_W-1:0] start_velocity_reg;
    logic [REG_W-1:0] start_accel_reg;
    logic             q_valid;
    logic             q_ready;
    q_entry_t         q_data;
    back_stat_t       stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_velocity_reg <= VEL_RESET;
            start_accel_reg    <= ACC_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_VELOCITY: start_velocity_reg <= cfg_data;
                CFG_START_ACCEL:    start_accel_reg    <= cfg_data;
                default:            start_accel_reg    <= start_accel_reg;
            endcase
        end
    end

    qjtg_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data)
    );

    qjtg_back #(
        .TICK_BITS (TICK_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_data         (q_data),
        .start_velocity ($signed(start_velocity_reg)),
        .start_accel    ($signed(start_accel_reg)),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .stat           (stat)
    );

`ifndef SYNTHESIS
    a_run_fin_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(stat.running && stat.finished))
        else $error("running and finished both set");

    a_out_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.busy_res && out_data.done_res))
        else $error("output beat busy and done together");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(stat.done_state))
        else $error("output beat without finished sequence");

    a_take_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && q_ready) |-> stat.idle)
        else $error("queue popped while sequencer busy");
`endif

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks the quintic joint trajectory core against a fixed point predictor
// ----------------------------------------------------------------------------
// start and tick beats are queued by an initial block and driven by a clocked
// driver with random gaps; a clocked monitor compares each output beat with
// the predicted setpoints and flags. the run covers directed edge cases, full
// moves with random content, several coefficient settings and a long receiver
// hold-off that fills the core and stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
    import qjtg_pkg::*;

    localparam int LIMIT = 2000000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    logic      cfg_we;
    logic [0:0] cfg_index;
    logic [REG_W-1:0] cfg_data;

    quintic_joint_trajectory_generator_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic signed [15:0] pr_vel;
    logic signed [15:0] pr_acc;
    logic [15:0]        pr_elapsed;
    logic [15:0]        pr_total;
    logic signed [31:0] pr_start [3];
    logic signed [31:0] pr_target [3];
    logic signed [31:0] pr_cmd [3];
    logic               pr_running;
    logic               pr_finished;

    in_item_t  pending_beats [$];
    out_item_t expected_setpoints [$];
    int        errors;
    int        cycles;
    int        beats_sent;
    int        beats_seen;
    int        ticks_interp;
    int        hold_cycles;
    logic      in_busy;

    function automatic longint floor_shift(longint x, int n);
        return x >>> n;
    endfunction

    function automatic longint quintic_s(longint t);
        longint v;
        longint a;
        longint c [5];
        longint acc;
        v = pr_vel;
        a = pr_acc;
        c[0] = 2 * v;
        c[1] = a;
        c[2] = 10 * 8192 - 12 * v - 3 * a;
        c[3] = -15 * 8192 + 16 * v + 3 * a;
        c[4] = 6 * 8192 - 6 * v - a;
        acc = c[4] * 128;
        for (int k = 3; k >= 0; k--)
            acc = c[k] * 128 + floor_shift(acc * t, 20);
        return floor_shift(acc * t, 20);
    endfunction

    function automatic logic signed [31:0] sat32(longint x);
        if (x > 64'sd2147483647)
            return 32'sh7fffffff;
        if (x < -64'sd2147483648)
            return 32'sh80000000;
        return x[31:0];
    endfunction

    task automatic predict_setpoints(input in_item_t it);
        logic signed [31:0] tg [3];
        logic signed [31:0] ms [3];
        longint t;
        longint s;
        longint diff;
        out_item_t r;
        tg = '{it.target_a, it.target_b, it.target_c};
        ms = '{it.measured_a, it.measured_b, it.measured_c};
        if (it.opcode == 1'b0) begin
            for (int i = 0; i < 3; i++)
            begin
                pr_target[i] = tg[i];
                pr_start[i] = ms[i];
            end
            pr_total = it.move_ticks;
            pr_elapsed = '0;
            pr_running = 1'b1;
            pr_finished = 1'b0;
        end else if (it.enabled && pr_running) begin
            if (pr_total == 0 || pr_elapsed >= pr_total) begin
                for (int i = 0; i < 3; i++)
                    pr_cmd[i] = pr_target[i];
            end else begin
                ticks_interp++;
                t = (longint'(pr_elapsed) << 20) / longint'(pr_total);
                if (t > (64'sd1 << 20))
                    t = 64'sd1 << 20;
                s = quintic_s(t);
                for (int i = 0; i < 3; i++)
                begin
                    diff = longint'(pr_target[i]) - longint'(pr_start[i]);
                    pr_cmd[i] = sat32(longint'(pr_start[i]) + floor_shift(diff * s, 20));
                end
            end
            pr_elapsed = pr_elapsed + 16'd1;
            if (pr_elapsed >= pr_total) begin
                for (int i = 0; i < 3; i++)
                    pr_cmd[i] = pr_target[i];
                pr_elapsed = pr_total;
                pr_running = 1'b0;
                pr_finished = 1'b1;
            end
        end
        r.command_a = pr_cmd[0];
        r.command_b = pr_cmd[1];
        r.command_c = pr_cmd[2];
        r.busy_res = pr_running;
        r.done_res = pr_finished;
        expected_setpoints.push_back(r);
    endtask

    function automatic in_item_t rand_beat(logic op, logic en, logic [15:0] len);
        in_item_t it;
        it.opcode = op;
        it.enabled = en;
        it.target_a = $urandom;
        it.target_b = $urandom;
        it.target_c = $urandom;
        it.move_ticks = len;
        it.measured_a = $urandom;
        it.measured_b = $urandom;
        it.measured_c = $urandom;
        if ($urandom_range(0, 3) != 0) begin
            it.target_a = $signed(it.target_a) >>> $urandom_range(0, 12);
            it.measured_a = $signed(it.measured_a) >>> $urandom_range(0, 12);
        end
        return it;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // driver
    int gap_in;
    always @(negedge clk)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_in = 0;
        end else if (in_valid && !in_busy) begin
            // beat still waiting
        end else if (gap_in > 0) begin
            gap_in--;
            in_valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
            in_data <= pending_beats.pop_front();
            in_valid <= 1'b1;
            gap_in = gap_len();
        end else begin
            in_valid <= 1'b0;
        end
    end

    // in_busy marks that the valid beat was accepted at the last rising edge
    always @(posedge clk)
    begin
        in_busy <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready) begin
            predict_setpoints(in_data);
            beats_sent++;
        end
    end

    // receiver backpressure
    int gap_out;
    always @(negedge clk)
    begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            gap_out = 0;
        end else if (hold_cycles > 0) begin
            hold_cycles--;
            out_ready <= 1'b0;
        end else if (gap_out > 0) begin
            gap_out--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            gap_out = gap_len();
        end
    end

    // monitor
    always @(posedge clk)
    begin
        out_item_t e;
        if (rst_n && out_valid && out_ready) begin
            beats_seen++;
            if (expected_setpoints.size() == 0) begin
                $error("unexpected output beat %h", out_data);
                errors++;
            end else begin
                e = expected_setpoints.pop_front();
                if (out_data.command_a !== e.command_a) begin
                    $error("command_a exp %h got %h", e.command_a, out_data.command_a);
                    errors++;
                end
                if (out_data.command_b !== e.command_b) begin
                    $error("command_b exp %h got %h", e.command_b, out_data.command_b);
                    errors++;
                end
                if (out_data.command_c !== e.command_c) begin
                    $error("command_c exp %h got %h", e.command_c, out_data.command_c);
                    errors++;
                end
                if (out_data.busy_res !== e.busy_res) begin
                    $error("busy_res exp %b got %b", e.busy_res, out_data.busy_res);
                    errors++;
                end
                if (out_data.done_res !== e.done_res) begin
                    $error("done_res exp %b got %b", e.done_res, out_data.done_res);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_beats.size() > 0 || in_valid || expected_setpoints.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_START_VELOCITY)
            pr_vel = val;
        else
            pr_acc = val;
    endtask

    task automatic queue_move(logic [15:0] len);
        pending_beats.push_back(rand_beat(1'b0, 1'($urandom_range(0, 1)), len));
        for (int k = 0; k <= len + 1; k++)
        begin
            if ($urandom_range(0, 19) == 0)
                pending_beats.push_back(rand_beat(1'b1, 1'b0, 16'($urandom)));
            pending_beats.push_back(rand_beat(1'b1, 1'b1, 16'($urandom)));
        end
    endtask

    logic [15:0] vel_set [5];
    logic [15:0] acc_set [5];
    int n;
    int m;

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_START_VELOCITY;
        cfg_data = '0;
        errors = 0;
        cycles = 0;
        beats_sent = 0;
        beats_seen = 0;
        ticks_interp = 0;
        hold_cycles = 0;
        pr_vel = VEL_RESET;
        pr_acc = ACC_RESET;
        pr_elapsed = '0;
        pr_total = '0;
        for (int i = 0; i < 3; i++)
        begin
            pr_start[i] = '0;
            pr_target[i] = '0;
            pr_cmd[i] = '0;
        end
        pr_running = 1'b0;
        pr_finished = 1'b1;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: idle tick, zero length, extremes, restart, disabled tick
        pending_beats.push_back(rand_beat(1'b1, 1'b1, 16'd5));
        pending_beats.push_back(rand_beat(1'b0, 1'b0, 16'd0));
        pending_beats.push_back(rand_beat(1'b1, 1'b0, 16'd0));
        pending_beats.push_back(rand_beat(1'b1, 1'b1, 16'd0));
        pending_beats.push_back(rand_beat(1'b1, 1'b1, 16'd0));
        pending_beats.push_back(in_item_t'{1'b0, 1'b1, 32'sh7fffffff, 32'sh80000000,
                                32'sh7fffffff, 16'd4, 32'sh80000000, 32'sh7fffffff,
                                32'sh0});
        pending_beats.push_back(in_item_t'{1'b0, 1'b1, 32'sh7fffffff, 32'sh80000000,
                                32'sh7fffffff, 16'd4, 32'sh80000000, 32'sh7fffffff,
                                32'sh80000000});
        for (int k = 0; k < 5; k++)
            pending_beats.push_back(rand_beat(1'b1, 1'b1, 16'd0));
        pending_beats.push_back(rand_beat(1'b0, 1'b1, 16'd3));
        pending_beats.push_back(rand_beat(1'b1, 1'b1, 16'd0));
        pending_beats.push_back(rand_beat(1'b0, 1'b1, 16'hffff));
        pending_beats.push_back(rand_beat(1'b1, 1'b1, 16'd0));
        pending_beats.push_back(rand_beat(1'b1, 1'b0, 16'd0));
        pending_beats.push_back(rand_beat(1'b1, 1'b1, 16'd0));
        pending_beats.push_back(rand_beat(1'b0, 1'b1, 16'd1));
        pending_beats.push_back(rand_beat(1'b1, 1'b1, 16'd0));
        pending_beats.push_back(rand_beat(1'b1, 1'b1, 16'd0));
        wait_drained();

        // long receiver hold-off while the sender keeps offering beats
        hold_cycles = 400;
        queue_move(16'd6);
        wait_drained();

        vel_set = '{16'h0000, 16'h7fff, 16'h8000, 16'h1234, VEL_RESET};
        acc_set = '{16'h8000, 16'h0000, 16'h7fff, 16'hf00d, ACC_RESET};
        for (int p = 0; p < 5; p++)
        begin
            write_reg(CFG_START_VELOCITY, vel_set[p]);
            write_reg(CFG_START_ACCEL, acc_set[p]);
            n = 0;
            while (n < 100)
            begin
                if ($urandom_range(0, 9) == 0) begin
                    pending_beats.push_back(rand_beat(1'($urandom_range(0, 1)),
                                            1'($urandom_range(0, 1)), 16'($urandom)));
                    n++;
                end else begin
                    m = pending_beats.size();
                    queue_move($urandom_range(0, 9) == 0 ? 16'($urandom_range(20, 40))
                                                          : 16'($urandom_range(0, 8)));
                    n = n + pending_beats.size() - m;
                end
            end
            wait_drained();
        end

        $display("sent %0d beats, checked %0d output beats, %0d interpolating ticks",
                 beats_sent, beats_seen, ticks_interp);
        $display("five coefficient settings incl. extremes and one long output stall");
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
